[hw/rtl/dhd_pkg.sv]
// Shared types and constants for the dictionary halfword decompressor.
package dhd_pkg;

    // Field format constants.
    localparam int DICT_ENTRIES_DEF = 64;
    localparam int LIT_BITS         = 16;
    localparam int IDX_BITS         = 6;
    localparam int COUNT_BYTES      = 4;
    localparam int BUF_BITS         = 24;
    localparam int CNT_BITS         = 5;

    // Parser phase within one field.
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DICT   = 2'd1,
        PH_STREAM = 2'd2,
        PH_IDLE   = 2'd3
    } phase_t;

    // One decoded token, before the dictionary data is merged in.
    typedef struct packed {
        logic                lit;
        logic [LIT_BITS-1:0] literal;
        logic                oob;
        logic                last;
    } tok_t;

    // Everything one input byte yields toward the result register.
    typedef struct packed {
        logic [1:0] n;
        tok_t       tok0;
        tok_t       tok1;
    } parse_res_t;

endpackage

[hw/rtl/dhd_dict.sv]
// Dictionary store with one write port and two registered read ports.
module dhd_dict #(
    parameter int DICT_ENTRIES = dhd_pkg::DICT_ENTRIES_DEF,
    parameter int AW           = $clog2(DICT_ENTRIES)
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic [dhd_pkg::LIT_BITS-1:0] wdata,
    input  logic                         re,
    input  logic [AW-1:0]                raddr0,
    input  logic [AW-1:0]                raddr1,
    output logic [dhd_pkg::LIT_BITS-1:0] rdata0,
    output logic [dhd_pkg::LIT_BITS-1:0] rdata1
);
    import dhd_pkg::*;

    logic [LIT_BITS-1:0] mem [DICT_ENTRIES];

    // Dictionary words are loaded during the dictionary phase of a field.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Both token lookups of a byte are read at the same edge the byte is taken.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata0 <= mem[raddr0];
            rdata1 <= mem[raddr1];
        end
    end

endmodule

[hw/rtl/dhd_parse.sv]
// Field parser: header count, dictionary load and bit stream token decode.
module dhd_parse #(
    parameter int DICT_ENTRIES = dhd_pkg::DICT_ENTRIES_DEF,
    parameter int AW           = $clog2(DICT_ENTRIES)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [7:0]                   in_byte,
    input  logic                         start_req,
    output dhd_pkg::parse_res_t          res,
    output logic                         dict_we,
    output logic [AW-1:0]                dict_waddr,
    output logic [dhd_pkg::LIT_BITS-1:0] dict_wdata,
    output logic [AW-1:0]                dict_raddr0,
    output logic [AW-1:0]                dict_raddr1
);
    import dhd_pkg::*;

    localparam int CW = AW + 1;
    localparam int IW = IDX_BITS + AW;
    localparam logic [IW-1:0]       ENTRIES_W  = IW'(DICT_ENTRIES);
    localparam logic [CW-1:0]       HDR_END    = CW'(COUNT_BYTES - 1);
    localparam logic [CW-1:0]       DICT_END   = CW'(2 * DICT_ENTRIES - 1);
    localparam logic [CNT_BITS-1:0] NEED_LIT   = CNT_BITS'(1 + LIT_BITS);
    localparam logic [CNT_BITS-1:0] NEED_IDX   = CNT_BITS'(1 + IDX_BITS);
    localparam logic [CNT_BITS-1:0] BUF_FULL   = CNT_BITS'(BUF_BITS);

    phase_t                phase_reg, phase_next;
    logic [CW-1:0]         hbc_reg, hbc_next;
    logic [31:0]           rem_reg, rem_next;
    logic [7:0]            hold_reg, hold_next;
    logic [BUF_BITS-1:0]   buf_reg, buf_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;

    // State as seen by this byte: a start beat restarts the field first.
    phase_t                ph_e;
    logic [CW-1:0]         hbc_e;
    logic [31:0]           rem_e;
    logic [7:0]            hold_e;
    logic [BUF_BITS-1:0]   buf_e;
    logic [CNT_BITS-1:0]   cnt_e;

    assign ph_e   = start_req ? PH_HEADER : phase_reg;
    assign hbc_e  = start_req ? '0 : hbc_reg;
    assign rem_e  = start_req ? '0 : rem_reg;
    assign hold_e = start_req ? '0 : hold_reg;
    assign buf_e  = start_req ? '0 : buf_reg;
    assign cnt_e  = start_req ? '0 : cnt_reg;

    // Header: the count shifts in through the remaining-words register.
    logic [31:0] shift_s;
    logic [31:0] rounded;
    logic        hdr_done;
    logic        dict_done;

    assign shift_s   = {rem_e[23:0], in_byte};
    assign rounded   = {1'b0, shift_s[31:1]} + {31'd0, shift_s[0]};
    assign hdr_done  = (hbc_e == HDR_END);
    assign dict_done = (hbc_e == DICT_END);

    // Stream: left-align the pending bits so the oldest bit sits at the top.
    logic [BUF_BITS-1:0] buf_s;
    logic [CNT_BITS-1:0] c0, c1;
    logic [BUF_BITS-1:0] win0, win1;
    logic                lit0, lit1;
    logic [CNT_BITS-1:0] need0, need1;
    logic                in_stream;
    logic                ok0, ok1;
    logic [IW-1:0]       idx0_w, idx1_w;

    assign buf_s     = {buf_e[BUF_BITS-9:0], in_byte};
    assign c0        = cnt_e + CNT_BITS'(8);
    assign win0      = buf_s << (BUF_FULL - c0);
    assign lit0      = win0[BUF_BITS-1];
    assign need0     = lit0 ? NEED_LIT : NEED_IDX;
    assign in_stream = (ph_e == PH_STREAM);
    assign ok0       = in_stream && (rem_e != 32'd0) && (c0 >= need0);

    // Second token starts right after the first one.
    assign win1  = lit0 ? (win0 << (1 + LIT_BITS)) : (win0 << (1 + IDX_BITS));
    assign c1    = c0 - need0;
    assign lit1  = win1[BUF_BITS-1];
    assign need1 = lit1 ? NEED_LIT : NEED_IDX;
    assign ok1   = ok0 && (rem_e != 32'd1) && (c1 >= need1);

    // Dictionary indexes, with an out-of-range flag for small dictionaries.
    assign idx0_w      = {{AW{1'b0}}, win0[BUF_BITS-2 -: IDX_BITS]};
    assign idx1_w      = {{AW{1'b0}}, win1[BUF_BITS-2 -: IDX_BITS]};
    assign dict_raddr0 = idx0_w[AW-1:0];
    assign dict_raddr1 = idx1_w[AW-1:0];

    // Tokens handed to the result register.
    always_comb
    begin
        res.n            = {ok0 & ok1, ok0 ^ ok1};
        res.tok0.lit     = lit0;
        res.tok0.literal = win0[BUF_BITS-2 -: LIT_BITS];
        res.tok0.oob     = (idx0_w >= ENTRIES_W);
        res.tok0.last    = (rem_e == 32'd1);
        res.tok1.lit     = lit1;
        res.tok1.literal = win1[BUF_BITS-2 -: LIT_BITS];
        res.tok1.oob     = (idx1_w >= ENTRIES_W);
        res.tok1.last    = (rem_e == 32'd2);
    end

    // Dictionary write on the low byte of each word.
    assign dict_we    = accept && (ph_e == PH_DICT) && hbc_e[0];
    assign dict_waddr = hbc_e[CW-1:1];
    assign dict_wdata = {hold_e, in_byte};

    // Next phase.
    always_comb
    begin
        phase_next = ph_e;
        case (ph_e)
            PH_HEADER:
            begin
                if (hdr_done)
                begin
                    phase_next = PH_DICT;
                end
            end
            PH_DICT:
            begin
                if (dict_done)
                begin
                    phase_next = (rem_e == 32'd0) ? PH_IDLE : PH_STREAM;
                end
            end
            PH_STREAM:
            begin
                if (rem_next == 32'd0)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = ph_e;
            end
        endcase
    end

    // Counters, count and bit buffer for each phase.
    always_comb
    begin
        hbc_next  = hbc_e;
        rem_next  = rem_e;
        hold_next = hold_e;
        buf_next  = buf_e;
        cnt_next  = cnt_e;
        case (ph_e)
            PH_HEADER:
            begin
                rem_next = hdr_done ? rounded : shift_s;
                hbc_next = hdr_done ? '0 : hbc_e + CW'(1);
            end
            PH_DICT:
            begin
                if (!hbc_e[0])
                begin
                    hold_next = in_byte;
                end
                hbc_next = dict_done ? '0 : hbc_e + CW'(1);
            end
            PH_STREAM:
            begin
                buf_next = buf_s;
                rem_next = rem_e - {30'd0, res.n};
                if (ok1)
                begin
                    cnt_next = c1 - need1;
                end
                else if (ok0)
                begin
                    cnt_next = c1;
                end
                else
                begin
                    cnt_next = c0;
                end
            end
            default:
            begin
                hbc_next = hbc_e;
            end
        endcase
    end

    // Field state registers advance once per accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            hbc_reg   <= '0;
            rem_reg   <= '0;
            hold_reg  <= '0;
            buf_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            hbc_reg   <= hbc_next;
            rem_reg   <= rem_next;
            hold_reg  <= hold_next;
            buf_reg   <= buf_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[hw/rtl/dhd_out.sv]
// Result register: holds up to two halfwords of one byte and drains them in order.
module dhd_out (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  dhd_pkg::parse_res_t          res,
    input  logic [dhd_pkg::LIT_BITS-1:0] rdata0,
    input  logic [dhd_pkg::LIT_BITS-1:0] rdata1,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [dhd_pkg::LIT_BITS-1:0] halfword,
    output logic                         last,
    output logic                         room
);
    import dhd_pkg::*;

    logic [1:0] left_reg;
    logic       head_reg;
    tok_t       tok0_reg, tok1_reg;
    tok_t       tok_sel;
    logic [LIT_BITS-1:0] rd_sel;
    logic       out_beat;

    assign out_valid = (left_reg != 2'd0);
    assign out_beat  = out_valid && out_ready;
    assign room      = (left_reg == 2'd0) || ((left_reg == 2'd1) && out_ready);

    // Pending count and slot pointer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= 2'd0;
            head_reg <= 1'b0;
        end
        else if (accept)
        begin
            left_reg <= res.n;
            head_reg <= 1'b0;
        end
        else if (out_beat)
        begin
            left_reg <= left_reg - 2'd1;
            head_reg <= 1'b1;
        end
    end

    // Token payload, loaded with the byte.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tok0_reg <= res.tok0;
            tok1_reg <= res.tok1;
        end
    end

    // Pick the current slot and merge in the dictionary word.
    assign tok_sel  = head_reg ? tok1_reg : tok0_reg;
    assign rd_sel   = head_reg ? rdata1 : rdata0;
    assign halfword = tok_sel.lit ? tok_sel.literal :
                      (tok_sel.oob ? '0 : rd_sel);
    assign last     = tok_sel.last;

endmodule

[hw/rtl/dictionary_halfword_decompressor_unit.sv]
// Top level of the dictionary halfword decompressor.
//
//   Channel | Signals                          | Dir | Beat moves
//   --------+----------------------------------+-----+---------------------------
//   in      | in_valid, in_ready, in_byte,     | in  | one byte of the field
//           | start_req                        |     |
//   out     | out_valid, out_ready, halfword,  | out | one decoded halfword
//           | last                             |     |
//
// An accepted byte updates the field state and issues its dictionary reads at
// the same edge, and its zero, one or two halfwords wait in the result
// register. A byte yielding two halfwords occupies that register until both
// have drained, since the single output port drains one halfword per cycle
// while out_ready is high; the next byte can be taken as the last of them
// drains. Reset is asynchronous and returns the parser to the header phase;
// the dictionary is not cleared and needs no clearing pass. A stalled output
// holds the input off only while it would overflow the result register.
module dictionary_halfword_decompressor_unit #(
    parameter int DICT_ENTRIES = dhd_pkg::DICT_ENTRIES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   in_byte,
    input  logic                         start_req,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [dhd_pkg::LIT_BITS-1:0] halfword,
    output logic                         last
);
    import dhd_pkg::*;

    localparam int AW = $clog2(DICT_ENTRIES);

    logic                accept;
    parse_res_t          res;
    logic                dict_we;
    logic [AW-1:0]       dict_waddr;
    logic [LIT_BITS-1:0] dict_wdata;
    logic [AW-1:0]       dict_raddr0, dict_raddr1;
    logic [LIT_BITS-1:0] rdata0, rdata1;

    assign accept = in_valid && in_ready;

    // Field parser and token decode.
    dhd_parse #(
        .DICT_ENTRIES (DICT_ENTRIES),
        .AW           (AW)
    ) u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_byte     (in_byte),
        .start_req   (start_req),
        .res         (res),
        .dict_we     (dict_we),
        .dict_waddr  (dict_waddr),
        .dict_wdata  (dict_wdata),
        .dict_raddr0 (dict_raddr0),
        .dict_raddr1 (dict_raddr1)
    );

    // Dictionary memory.
    dhd_dict #(
        .DICT_ENTRIES (DICT_ENTRIES),
        .AW           (AW)
    ) u_dict (
        .clk    (clk),
        .we     (dict_we),
        .waddr  (dict_waddr),
        .wdata  (dict_wdata),
        .re     (accept),
        .raddr0 (dict_raddr0),
        .raddr1 (dict_raddr1),
        .rdata0 (rdata0),
        .rdata1 (rdata1)
    );

    // Result register and output handshake.
    dhd_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .res       (res),
        .rdata0    (rdata0),
        .rdata1    (rdata1),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .halfword  (halfword),
        .last      (last),
        .room      (in_ready)
    );

`ifndef ASSERT_OFF
    // A pending halfword that is stalled must never be overwritten by a new byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("byte taken while a stalled halfword is pending");

    // The final halfword of a field leaves nothing behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> !out_valid)
        else $error("halfword still pending after the last one");

    // A start byte is a header byte and yields no halfword.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && start_req) |=> !out_valid)
        else $error("start byte produced a halfword");
`endif

endmodule
